// ===== rtl/pft_pkg.sv =====
package pft_pkg;

   // Default longest varint, in bytes, before it counts as malformed.
   localparam int MAX_VARINT_BYTES_DEF = 9;

   // Varint accumulator and payload length counter.
   localparam int ACC_W = 64;
   localparam int LEN_W = 63;

   // Key layout: wire type in the low bits, field number above it.
   localparam int KEY_SHIFT     = 3;
   localparam int FIELD_FULL_W  = 32;
   localparam int FIELD_W       = 4;
   localparam int MASK_W        = 9;
   localparam logic [MASK_W-1:0] MASK_RESET = 9'd382;

   localparam logic [KEY_SHIFT-1:0] WIRE_VARINT = 3'd0;
   localparam logic [KEY_SHIFT-1:0] WIRE_LEN    = 3'd2;

   // Result queue.
   localparam int RES_FIFO_DEPTH = 4;
   localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
   localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_EMPTY   = 2'd1,
      EV_DONE    = 2'd2,
      EV_ERROR   = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_WIRE_TYPE = 2'd1,
      ERR_MALFORMED = 2'd2,
      ERR_TRUNCATED = 2'd3
   } error_type;

   typedef struct packed {
      event_type          ev;
      logic [FIELD_W-1:0] field_number;
      logic [7:0]         payload_byte;
      logic               first_of_field;
      logic               last_of_field;
      error_type          error_code;
      logic               last_result;
   } result_type;

endpackage

// ===== rtl/pft_parser.sv =====
module pft_parser
   import pft_pkg::*;
#(
   parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        in_byte,
   input  logic              in_eom,
   input  logic [MASK_W-1:0] kept_mask,
   output logic [1:0]        res_count,
   output result_type        res0,
   output result_type        res1
);

   localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 1);

   typedef enum logic [4:0] {
      PH_KEY     = 5'b00001,
      PH_VALUE   = 5'b00010,
      PH_LEN     = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_DRAIN   = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic               kept_ff, kept_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic               first_ff, first_in;

   logic [6:0]           part;
   logic [CNT_W-1:0]     cnt_inc;
   logic [6:0]           shamt;
   logic [ACC_W-1:0]     feed_acc;
   logic                 malformed;
   logic                 complete;
   logic [KEY_SHIFT-1:0] key_wt;
   logic [FIELD_W-1:0]   key_lo;
   logic                 key_kept;
   logic [2*MASK_W-1:0]  mask_ext;
   logic [LEN_W-1:0]     len_val;
   error_type            err;
   logic                 a_valid, b_valid;
   result_type           res_a, res_b;

   // Shared varint byte step.
   assign part      = in_byte[6:0];
   assign cnt_inc   = cnt_ff + 1'b1;
   assign shamt     = 7'(cnt_ff) * 7'd7;
   assign feed_acc  = acc_ff | (ACC_W'(part) << shamt);
   assign malformed = in_byte[7] ? (cnt_inc >= CNT_W'(MAX_VARINT_BYTES))
                                 : ((part == 7'd0) && (cnt_ff != '0));
   assign complete  = !in_byte[7] && !malformed;

   // Key decode. Field numbers above eight are never kept.
   assign key_wt   = feed_acc[KEY_SHIFT-1:0];
   assign key_lo   = feed_acc[KEY_SHIFT +: FIELD_W];
   assign mask_ext = {{MASK_W{1'b0}}, kept_mask};
   assign key_kept = (feed_acc[KEY_SHIFT+FIELD_W +: FIELD_FULL_W-FIELD_W] == '0) &&
                     (key_lo <= FIELD_W'(MASK_W - 1)) && mask_ext[key_lo];

   // Length saturates when it does not fit the counter.
   assign len_val = feed_acc[ACC_W-1] ? {LEN_W{1'b1}} : feed_acc[LEN_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      field_in = field_ff;
      kept_in  = kept_ff;
      rem_in   = rem_ff;
      first_in = first_ff;
      err      = ERR_NONE;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      res_a    = '0;
      res_b    = '0;
      res0     = '0;
      res1     = '0;
      res_count = 2'd0;

      unique case (phase_ff)
         PH_KEY: begin
            acc_in = feed_acc;
            cnt_in = cnt_inc;
            if (malformed) begin
               err = ERR_MALFORMED;
            end else if (complete) begin
               acc_in = '0;
               cnt_in = '0;
               if (key_wt == WIRE_VARINT) begin
                  phase_in = PH_VALUE;
               end else if (key_wt == WIRE_LEN) begin
                  kept_in  = key_kept;
                  field_in = key_kept ? key_lo : '0;
                  phase_in = PH_LEN;
               end else begin
                  err = ERR_WIRE_TYPE;
               end
            end
         end
         PH_VALUE: begin
            acc_in = feed_acc;
            cnt_in = cnt_inc;
            if (malformed) begin
               err = ERR_MALFORMED;
            end else if (complete) begin
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = PH_KEY;
            end
         end
         PH_LEN: begin
            acc_in = feed_acc;
            cnt_in = cnt_inc;
            if (malformed) begin
               err = ERR_MALFORMED;
            end else if (complete) begin
               acc_in = '0;
               cnt_in = '0;
               if (len_val == '0) begin
                  if (kept_ff) begin
                     a_valid            = 1'b1;
                     res_a.ev           = EV_EMPTY;
                     res_a.field_number = field_ff;
                  end
                  phase_in = PH_KEY;
               end else begin
                  rem_in   = len_val;
                  first_in = 1'b1;
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (kept_ff) begin
               a_valid              = 1'b1;
               res_a.ev             = EV_PAYLOAD;
               res_a.field_number   = field_ff;
               res_a.payload_byte   = in_byte;
               res_a.first_of_field = first_ff;
               res_a.last_of_field  = (rem_ff == LEN_W'(1));
            end
            first_in = 1'b0;
            rem_in   = rem_ff - 1'b1;
            if (rem_ff == LEN_W'(1)) begin
               phase_in = PH_KEY;
            end
         end
         PH_DRAIN: begin
         end
         default: begin
         end
      endcase

      if (err != ERR_NONE) begin
         a_valid          = 1'b1;
         res_a            = '0;
         res_a.ev         = EV_ERROR;
         res_a.error_code = err;
         acc_in           = '0;
         cnt_in           = '0;
         phase_in         = PH_DRAIN;
      end

      if (in_eom) begin
         if ((err == ERR_NONE) && (phase_ff != PH_DRAIN)) begin
            b_valid = 1'b1;
            if ((phase_in == PH_KEY) && (cnt_in == '0)) begin
               res_b.ev = EV_DONE;
            end else begin
               res_b.ev         = EV_ERROR;
               res_b.error_code = ERR_TRUNCATED;
            end
         end
         phase_in = PH_KEY;
         acc_in   = '0;
         cnt_in   = '0;
         field_in = '0;
         kept_in  = 1'b0;
         rem_in   = '0;
         first_in = 1'b0;
      end

      if (a_valid && b_valid) begin
         res0              = res_a;
         res1              = res_b;
         res1.last_result  = 1'b1;
         res_count         = 2'd2;
      end else if (a_valid) begin
         res0              = res_a;
         res0.last_result  = 1'b1;
         res_count         = 2'd1;
      end else if (b_valid) begin
         res0              = res_b;
         res0.last_result  = 1'b1;
         res_count         = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEY;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         field_ff <= '0;
         kept_ff  <= 1'b0;
         rem_ff   <= '0;
         first_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         field_ff <= field_in;
         kept_ff  <= kept_in;
         rem_ff   <= rem_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== rtl/pft_result_fifo.sv =====
module pft_result_fifo
   import pft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  result_type push0,
   input  result_type push1,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type             entry_ff [RES_FIFO_DEPTH];
   logic [RES_PTR_W-1:0]   wr_ff, wr_in;
   logic [RES_PTR_W-1:0]   rd_ff, rd_in;
   logic [RES_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = entry_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // Room for the two results one byte can cause.
   assign space     = (cnt_ff <= RES_CNT_W'(RES_FIFO_DEPTH - 2));

   assign wr_in  = wr_ff + RES_PTR_W'(push_count);
   assign rd_in  = rd_ff + RES_PTR_W'(pop);
   assign cnt_in = cnt_ff + RES_CNT_W'(push_count) - RES_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ff + 1'b1] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/protobuf_field_tokenizer.sv =====
// Channel  Dir  Handshake         Contents
// req      in   tvalid / tready   tdata = message byte, tlast = end of message
// rsp      out  tvalid / tready   tdata = field, payload, marks, error code;
//                                 tuser = event kind, tlast = last result of a byte
// csr      in   csr_we            csr_wdata = kept field mask
//
// One message byte is taken per cycle while req_tready is high. A byte is held in the input
// register after its transfer, and its results enter the result queue when it is parsed.
// Bytes that cause two results (a final byte with its own result) leave as two rsp transfers;
// the four-entry result queue absorbs them and throttles req_tready.
// Reset is synchronous and active high; it restores the mask to its reset value and
// puts the parser at the start of a key. A stall on rsp holds the queue head steady.
// A held byte is parsed only while the queue has room for two results, so req_tready
// drops once the queue lacks that room and the input register is occupied.
module protobuf_field_tokenizer
   import pft_pkg::*;
#(
   parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [3:0] field_number, [11:4] payload_byte, [12] first_of_field,
   // [13] last_of_field, [15:14] error_code
   output logic [15:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,   // [1:0] event_res
   output logic              rsp_tlast,
   input  logic              csr_we,
   input  logic [MASK_W-1:0] csr_wdata
);

   // Input register in front of the parser.
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_eom_ff;
   logic [MASK_W-1:0] mask_ff;

   logic       step;
   logic       space;
   logic       req_xfer;
   logic [1:0] res_count;
   logic [1:0] push_count;
   result_type res0, res1, head;

   // The held byte is parsed once the queue can take whatever it produces.
   assign step       = in_valid_ff && space;
   assign req_tready = !in_valid_ff || step;
   assign req_xfer   = req_tvalid && req_tready;
   assign push_count = step ? res_count : 2'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mask_ff     <= MASK_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_eom_ff  <= req_tlast;
      end
   end

   pft_parser #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .in_eom    (in_eom_ff),
      .kept_mask (mask_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   pft_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .space      (space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (head)
   );

   // Output fields, packed from the lowest bit up.
   assign rsp_tdata = {head.error_code, head.last_of_field, head.first_of_field,
                       head.payload_byte, head.field_number};
   assign rsp_tuser = head.ev;
   assign rsp_tlast = head.last_result;

endmodule

// ===== rtl/pft_checker.sv =====
module pft_checker
   import pft_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [15:0]       rsp_tdata,
   input logic [1:0]        rsp_tuser,
   input logic              rsp_tlast
);

   // Reset empties the result queue and opens the input.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");

   // An error or a message end always closes the results of its byte.
   a_final_event_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == EV_ERROR) || (rsp_tuser == EV_DONE)) |-> rsp_tlast)
      else $error("error or message end is not the last result of its byte");

   // Field marks and payload appear only on payload transfers.
   a_marks_payload_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != EV_PAYLOAD) |-> (rsp_tdata[13:4] == '0))
      else $error("payload or marks on a non-payload result");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind protobuf_field_tokenizer pft_checker u_pft_checker (.*);
